// File: rtl/sync_word_command_deframer_unit_macros.svh
`ifndef SYNC_WORD_COMMAND_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_WORD_COMMAND_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SWCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SWCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/swcd_pkg.sv
package swcd_pkg;

    localparam int unsigned NUM_CELLS = 6;
    localparam int unsigned SYNC_CELLS = 4;

    localparam logic [7:0] CODE_FREQ  = 8'h31;
    localparam logic [7:0] CODE_DUTY  = 8'h32;
    localparam logic [7:0] CODE_RELAY = 8'h33;

    localparam logic [31:0] SYNC_RESET = 32'h7362_6572;

    localparam logic [1:0] KIND_FREQ  = 2'd0;
    localparam logic [1:0] KIND_DUTY  = 2'd1;
    localparam logic [1:0] KIND_RELAY = 2'd2;

    localparam logic [2:0] FILL_FULL = 3'd6;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
        logic [7:0] p0;
        logic [7:0] p1;
    } t_frame;

endpackage

// File: rtl/swcd_cell.sv
module swcd_cell (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_d,
    output logic [7:0] o_q,
    input  logic       i_cmp_en,
    input  logic [7:0] i_ref,
    input  logic       i_match,
    output logic       o_match
);

    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q     = r_q;
    assign o_match = i_match & (~i_cmp_en | (r_q == i_ref));

endmodule

// File: rtl/swcd_out_stage.sv
module swcd_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swcd_pkg::t_frame      i_frame,
    input  logic                  i_take,
    output logic                  o_valid,
    output logic [1:0]            o_kind,
    output logic [15:0]           o_value
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_value;
    logic        n_valid;
    logic        known;
    logic [1:0]  kind;
    logic [15:0] value;

    always_comb begin
        known = 1'b1;
        kind  = swcd_pkg::KIND_FREQ;
        value = {i_frame.p1, i_frame.p0};
        unique case (i_frame.code)
            swcd_pkg::CODE_FREQ: begin
                kind = swcd_pkg::KIND_FREQ;
            end
            swcd_pkg::CODE_DUTY: begin
                kind = swcd_pkg::KIND_DUTY;
            end
            swcd_pkg::CODE_RELAY: begin
                kind  = swcd_pkg::KIND_RELAY;
                value = {15'd0, (i_frame.p0 != 8'd0)};
            end
            default: begin
                known = 1'b0;
            end
        endcase
        n_valid = (r_valid & ~i_take) | (i_frame.hit & known);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.hit && known) begin
            r_kind  <= kind;
            r_value <= value;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;

endmodule

// File: rtl/sync_word_command_deframer_unit.sv
// Sync-word command deframer. Each accepted word is one received byte; a frame is four sync
// bytes, a code byte and two parameter bytes (low byte first). A matched frame with code '1',
// '2' or '3' yields one command word (frequency, duty, relay); other codes are consumed
// silently, and unmatched bytes slide out one at a time. The block takes one byte every cycle
// unless a held command is not taken: six byte cells shift on each accepted byte, the sync
// compare runs along the cell chain in the same cycle, and a one-entry output register holds
// the command until taken. A command appears in the cycle after the byte that completes its
// frame. The sync word is written through the configuration channel, which is always ready.
`include "sync_word_command_deframer_unit_macros.svh"

module sync_word_command_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output logic [1:0]  o_command_kind,
    output logic [15:0] o_command_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_sync_word
);

    logic [31:0]      r_sync;
    logic [2:0]       r_fill;
    logic [2:0]       n_fill;
    logic             accept;
    logic             match;
    swcd_pkg::t_frame frame;

    logic [7:0] cell_d     [swcd_pkg::NUM_CELLS];
    logic [7:0] cell_q     [swcd_pkg::NUM_CELLS];
    logic [7:0] cell_ref   [swcd_pkg::NUM_CELLS];
    logic       cell_cmp   [swcd_pkg::NUM_CELLS];
    logic       match_in   [swcd_pkg::NUM_CELLS];
    logic       match_out  [swcd_pkg::NUM_CELLS];

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = ~o_cmd_valid | i_cmd_ready;
    assign accept      = i_rx_valid & o_rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= swcd_pkg::SYNC_RESET;
        end else if (i_cfg_valid) begin
            r_sync <= i_cfg_sync_word;
        end
    end

    // Cell 0 holds the newest byte; the oldest sync byte sits in the last cell.
    for (genvar k = 0; k < swcd_pkg::NUM_CELLS; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign cell_d[k] = i_rx_byte;
        end else begin : g_link
            assign cell_d[k] = cell_q[k-1];
        end
        if (k == swcd_pkg::NUM_CELLS - 1) begin : g_tail
            assign match_in[k] = 1'b1;
        end else begin : g_mid
            assign match_in[k] = match_out[k+1];
        end
        if (k >= swcd_pkg::NUM_CELLS - swcd_pkg::SYNC_CELLS) begin : g_sync
            assign cell_cmp[k] = 1'b1;
            assign cell_ref[k] =
                r_sync[8*(k-(swcd_pkg::NUM_CELLS-swcd_pkg::SYNC_CELLS)) +: 8];
        end else begin : g_data
            assign cell_cmp[k] = 1'b0;
            assign cell_ref[k] = 8'd0;
        end
        swcd_cell u_cell (
            .i_clk    (i_clk),
            .i_en     (accept),
            .i_d      (cell_d[k]),
            .o_q      (cell_q[k]),
            .i_cmp_en (cell_cmp[k]),
            .i_ref    (cell_ref[k]),
            .i_match  (match_in[k]),
            .o_match  (match_out[k])
        );
    end

    assign match = match_out[0];

    always_comb begin
        frame.hit  = accept & (r_fill == swcd_pkg::FILL_FULL) & match;
        frame.code = cell_q[1];
        frame.p0   = cell_q[0];
        frame.p1   = i_rx_byte;
        n_fill     = r_fill;
        if (accept) begin
            if (r_fill != swcd_pkg::FILL_FULL) begin
                n_fill = r_fill + 3'd1;
            end else if (match) begin
                n_fill = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 3'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    swcd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame),
        .i_take  (i_cmd_ready),
        .o_valid (o_cmd_valid),
        .o_kind  (o_command_kind),
        .o_value (o_command_value)
    );

    `SWCD_ASSERT_NOW(a_fill_range, 1'b1, r_fill <= swcd_pkg::FILL_FULL, "fill count out of range")
    `SWCD_ASSERT_NEXT(a_frame_clears, frame.hit, r_fill == 3'd0, "frame did not clear count")
    `SWCD_ASSERT_NEXT(a_fill_step, accept && (r_fill < swcd_pkg::FILL_FULL), r_fill == $past(r_fill) + 3'd1, "fill count did not advance")
    `SWCD_ASSERT_NOW(a_stall_blocks, o_cmd_valid && !i_cmd_ready, !o_rx_ready, "byte taken while command stalled")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
    } command_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic       hit;
        command_t   cmd;
    } script_row_t;

    localparam command_t NO_CMD = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte = '0;
    logic        o_cmd_valid;
    logic        i_cmd_ready = 1'b0;
    logic [1:0]  o_command_kind;
    logic [15:0] o_command_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_sync_word = '0;

    // Sideband that travels with each offered word; rows of the directed script
    // carry their own expected command instead of the predictor's.
    logic     typed_row = 1'b0;
    logic     typed_hit = 1'b0;
    command_t typed_cmd = '0;

    int         hold_asks = 0;
    int         hold_served = 0;
    int         hold_left = 0;
    logic       calm = 1'b0;

    logic [7:0]  win [0:6];
    int unsigned fill = 0;
    logic [31:0] sync_cur = swcd_pkg::SYNC_RESET;
    command_t    pending_cmds [$];

    int error_count = 0;
    int bytes_sent = 0;
    int cmds_checked = 0;
    int syncs_loaded = 0;
    int cycle_count = 0;

    script_row_t script_rows [0:21] = '{
        {8'h73, 1'b1, 1'b0, NO_CMD},
        {8'h73, 1'b1, 1'b0, NO_CMD},
        {8'h62, 1'b1, 1'b0, NO_CMD},
        {8'h65, 1'b1, 1'b0, NO_CMD},
        {8'h72, 1'b1, 1'b0, NO_CMD},
        {swcd_pkg::CODE_FREQ, 1'b1, 1'b0, NO_CMD},
        {8'hFF, 1'b1, 1'b0, NO_CMD},
        {8'hFF, 1'b1, 1'b1, swcd_pkg::KIND_FREQ, 16'hFFFF},
        {8'h73, 1'b0, 1'b0, NO_CMD},
        {8'h62, 1'b0, 1'b0, NO_CMD},
        {8'h65, 1'b0, 1'b0, NO_CMD},
        {8'h72, 1'b0, 1'b0, NO_CMD},
        {swcd_pkg::CODE_DUTY, 1'b0, 1'b0, NO_CMD},
        {8'h00, 1'b0, 1'b0, NO_CMD},
        {8'h80, 1'b0, 1'b0, NO_CMD},
        {8'h73, 1'b1, 1'b0, NO_CMD},
        {8'h62, 1'b1, 1'b0, NO_CMD},
        {8'h65, 1'b1, 1'b0, NO_CMD},
        {8'h72, 1'b1, 1'b0, NO_CMD},
        {swcd_pkg::CODE_RELAY, 1'b1, 1'b0, NO_CMD},
        {8'h00, 1'b1, 1'b0, NO_CMD},
        {8'hFF, 1'b1, 1'b1, swcd_pkg::KIND_RELAY, 16'h0000}
    };

    sync_word_command_deframer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_cmd_valid     (o_cmd_valid),
        .i_cmd_ready     (i_cmd_ready),
        .o_command_kind  (o_command_kind),
        .o_command_value (o_command_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_sync_word (i_cfg_sync_word)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sync_word_command_deframer_unit verification failed");
            $finish;
        end
    end

    function automatic logic deframe_byte(input logic [7:0] b, output command_t cmd);
        int unsigned pos;
        int i;
        pos = (fill > 6) ? 6 : fill;
        win[pos] = b;
        cmd = NO_CMD;
        if (pos + 1 < 7) begin
            fill = pos + 1;
            return 1'b0;
        end
        if ({win[0], win[1], win[2], win[3]} != sync_cur) begin
            for (i = 0; i < 6; i++) begin
                win[i] = win[i + 1];
            end
            fill = 6;
            return 1'b0;
        end
        fill = 0;
        case (win[4])
            swcd_pkg::CODE_FREQ: begin
                cmd.kind = swcd_pkg::KIND_FREQ;
                cmd.value = {win[6], win[5]};
            end
            swcd_pkg::CODE_DUTY: begin
                cmd.kind = swcd_pkg::KIND_DUTY;
                cmd.value = {win[6], win[5]};
            end
            swcd_pkg::CODE_RELAY: begin
                cmd.kind = swcd_pkg::KIND_RELAY;
                cmd.value = (win[5] != 8'h00) ? 16'd1 : 16'd0;
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (error_count < 100) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    always @(posedge i_clk) begin
        command_t want;
        command_t got;
        logic     hit;
        if (i_rst_n) begin
            if (i_rx_valid && o_rx_ready) begin
                hit = deframe_byte(i_rx_byte, want);
                if (typed_row) begin
                    if (typed_hit) begin
                        pending_cmds.push_back(typed_cmd);
                    end
                end else if (hit) begin
                    pending_cmds.push_back(want);
                end
            end
            if (o_cmd_valid && i_cmd_ready) begin
                got.kind = o_command_kind;
                got.value = o_command_value;
                if (pending_cmds.size() == 0) begin
                    flag_mismatch($sformatf("unexpected command kind %0d value %04h",
                                            got.kind, got.value));
                end else begin
                    want = pending_cmds.pop_front();
                    if (got.kind != want.kind) begin
                        flag_mismatch($sformatf("command_kind %0d, expected %0d",
                                                got.kind, want.kind));
                    end
                    if (got.value != want.value) begin
                        flag_mismatch($sformatf("command_value %04h, expected %04h",
                                                got.value, want.value));
                    end
                    cmds_checked++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_asks != hold_served) begin
            hold_served <= hold_asks;
            hold_left <= HOLD_CYCLES;
            i_cmd_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_cmd_ready <= 1'b0;
        end else if (!i_rst_n) begin
            i_cmd_ready <= 1'b0;
        end else begin
            i_cmd_ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic typed, input logic hit,
                             input command_t cmd);
        if (!calm && $urandom_range(99) < 36) begin
            i_rx_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 36);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        typed_row <= typed;
        typed_hit <= hit;
        typed_cmd <= cmd;
        do @(posedge i_clk); while (!o_rx_ready);
        bytes_sent++;
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, 1'b0, 1'b0, NO_CMD);
    endtask

    task automatic drain();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_sync(input logic [31:0] w);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_sync_word <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sync_cur = w;
        syncs_loaded++;
    endtask

    task automatic random_traffic(input int n);
        int start;
        int r;
        int k;
        int len;
        logic [7:0] code;
        logic [7:0] p0;
        start = bytes_sent;
        while (bytes_sent - start < n) begin
            r = $urandom_range(99);
            if (r < 65) begin
                case ($urandom_range(3))
                    0: code = swcd_pkg::CODE_FREQ;
                    1: code = swcd_pkg::CODE_DUTY;
                    2: code = swcd_pkg::CODE_RELAY;
                    default: code = 8'($urandom_range(255));
                endcase
                p0 = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
                for (k = 0; k < 4; k++) begin
                    send_plain(sync_cur[31 - 8 * k -: 8]);
                end
                send_plain(code);
                send_plain(p0);
                send_plain(8'($urandom_range(255)));
            end else if (r < 80) begin
                len = $urandom_range(3, 1);
                for (k = 0; k < len; k++) begin
                    send_plain(sync_cur[31 - 8 * k -: 8]);
                end
                send_plain(8'($urandom_range(255)));
            end else begin
                len = $urandom_range(4, 1);
                for (k = 0; k < len; k++) begin
                    send_plain(8'($urandom_range(255)));
                end
            end
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < 7; i++) begin
            win[i] = 8'h00;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script_rows[j]) begin
            send_byte(script_rows[j].rx, script_rows[j].typed, script_rows[j].hit,
                      script_rows[j].cmd);
        end

        random_traffic(300);
        calm = 1'b1;
        random_traffic(200);
        calm = 1'b0;

        hold_asks++;
        random_traffic(120);
        drain();
        random_traffic(100);

        load_sync(32'h0000_0000);
        random_traffic(250);
        load_sync(32'hFFFF_FFFF);
        random_traffic(250);
        repeat (2) begin
            load_sync($urandom);
            random_traffic(200);
        end
        load_sync(swcd_pkg::SYNC_RESET);
        random_traffic(150);

        drain();
        $display("Summary: %0d bytes deframed, %0d commands compared, %0d sync words loaded.",
                 bytes_sent, cmds_checked, syncs_loaded);
        $display("Covered sliding resync, all command codes, unknown codes and backpressure.");
        if (error_count == 0) begin
            $display("sync_word_command_deframer_unit verification clean");
        end else begin
            $display("sync_word_command_deframer_unit verification failed");
        end
        $finish;
    end

endmodule
